### rtl/rmhp_pkg.sv
// Shared types and constants for the running mean / high-pass filter.
`default_nettype none

package rmhp_pkg;

    // Window length register width (fixed by the register map)
    localparam int WIN_BITS     = 16;
    localparam int CFG_IDX_BITS = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HP_MODE = 4'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;      // zero average and warm-up count
        logic load;       // capture sample, pick multiplier and divisor
        logic mul_step;   // one shift-add step of avg * k
        logic add_x;      // add scaled sample, take magnitude
        logic div_step;   // one restoring division step
        logic commit;     // write back average, load result
        logic commit_err; // load the error result, state unchanged
    } rmhp_cmd_t;

    // Status seen by the controller
    typedef struct packed {
        logic action;     // item is a clear request
        logic win_zero;   // window length not configured
    } rmhp_status_t;

endpackage

`default_nettype wire

### rtl/rmhp_ctrl.sv
// Sequencer for the running mean filter: handshakes and step counting.
`default_nettype none

module rmhp_ctrl #(
    parameter int K_W   = 16,
    parameter int NUM_W = 58
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire rmhp_pkg::rmhp_status_t status,
    output rmhp_pkg::rmhp_cmd_t         cmd
);
    import rmhp_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             err_reg, err_next;
    logic             oval_reg, oval_next;
    logic             slot_free;

    assign slot_free = !oval_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = oval_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (status.action)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (status.win_zero)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        err_next   = 1'b0;
                        cnt_next   = CNT_W'(K_W - 1);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_ADD:
            begin
                cmd.add_x  = 1'b1;
                cnt_next   = CNT_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.commit     = !err_reg;
                    cmd.commit_err = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit || cmd.commit_err)
        begin
            oval_next = 1'b1;
        end
        else if (out_ready)
        begin
            oval_next = 1'b0;
        end
        else
        begin
            oval_next = oval_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

`default_nettype wire

### rtl/rmhp_dp.sv
// Datapath: average state, shift-add multiplier, restoring divider, output.
`default_nettype none

module rmhp_dp #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_BITS  = 16,
    parameter int K_W         = 16,
    parameter int NUM_W       = 58
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rmhp_pkg::rmhp_cmd_t            cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic [rmhp_pkg::WIN_BITS-1:0] window_length,
    input  wire logic                          highpass_mode,
    output logic signed [SAMPLE_BITS:0]        filtered,
    output logic                               error
);
    import rmhp_pkg::*;

    localparam int AVG_W = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int OUT_W = SAMPLE_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic signed [AVG_W-1:0]       avg_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [K_W-1:0]                k_reg;
    logic [K_W-1:0]                d_reg;
    logic                          warm_reg;
    logic                          neg_reg;
    logic signed [NUM_W-1:0]       acc_reg;
    logic [K_W-1:0]                rem_reg;
    logic signed [OUT_W-1:0]       filt_reg;
    logic                          err_reg;

    logic [K_W-1:0]          count_k, win_k;
    logic                    warm;
    logic signed [NUM_W-1:0] mul_next;
    logic signed [NUM_W-1:0] sum;
    logic [K_W:0]            rem_sh;
    logic [K_W:0]            rem_sub;
    logic                    qbit;
    logic signed [AVG_W-1:0] quo_avg;
    logic signed [AVG_W-1:0] avg_new;
    logic signed [OUT_W-1:0] ip_mag;
    logic signed [OUT_W-1:0] ip;
    logic signed [OUT_W-1:0] res;

    assign count_k = K_W'(count_reg);
    assign win_k   = K_W'(window_length);
    assign warm    = (count_k < win_k) && (count_reg != COUNT_MAX);

    // MSB-first shift-add of signed average times unsigned k
    assign mul_next = (acc_reg <<< 1)
                      + (k_reg[K_W-1] ? NUM_W'(avg_reg) : NUM_W'(0));
    assign sum      = acc_reg + (NUM_W'(x_reg) <<< FRAC_BITS);

    assign rem_sh  = {rem_reg, acc_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign qbit    = (rem_sh >= {1'b0, d_reg});

    // acc_reg holds the quotient magnitude once division ends
    assign quo_avg = AVG_W'(acc_reg);
    assign avg_new = neg_reg ? -quo_avg : quo_avg;
    assign ip_mag  = OUT_W'(acc_reg >> FRAC_BITS);
    assign ip      = neg_reg ? -ip_mag : ip_mag;
    assign res     = highpass_mode ? (OUT_W'(x_reg) - ip) : ip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            avg_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            avg_reg <= avg_new;
            if (warm_reg)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= sample;
            warm_reg <= warm;
            k_reg    <= warm ? count_k : (win_k - 1'b1);
            d_reg    <= warm ? (count_k + 1'b1) : win_k;
            acc_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= mul_next;
            k_reg   <= k_reg << 1;
        end
        else if (cmd.add_x)
        begin
            neg_reg <= sum[NUM_W-1];
            acc_reg <= sum[NUM_W-1] ? -sum : sum;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? rem_sub[K_W-1:0] : rem_sh[K_W-1:0];
            acc_reg <= {acc_reg[NUM_W-2:0], qbit};
        end

        if (cmd.commit)
        begin
            filt_reg <= res;
            err_reg  <= 1'b0;
        end
        else if (cmd.commit_err)
        begin
            filt_reg <= '0;
            err_reg  <= 1'b1;
        end
    end

    assign filtered = filt_reg;
    assign error    = err_reg;

endmodule

`default_nettype wire

### rtl/running_mean_highpass_filter.sv
// Running mean / high-pass filter top level: config registers, sequencer, datapath.
// A sample item runs a bit-serial multiply (one k bit a cycle), the sample add, then
//   the restoring divider (one quotient bit a cycle); its result then waits for a free
//   output slot. K_W = max(COUNT_BITS, 16), NUM_W = SAMPLE_BITS + FRAC_BITS + K_W + 2.
//   A new item is taken only once the previous item's result is emitted.
// Clear items give no result; error items give an error result. Reset (rst_n, async) zeroes state.
`default_nettype none

module running_mean_highpass_filter #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input item
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // [SAMPLE_BITS-1:0] sample
    input  wire logic                                s_tuser,  // [0] action (1 = clear)
    // result item
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((SAMPLE_BITS+8)/8)*8-1:0]         m_tdata,  // [SAMPLE_BITS:0] filtered
    output logic                                     m_tuser,  // [0] error
    // configuration writes
    input  wire logic                                cfg_wr_en,
    input  wire logic [rmhp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [rmhp_pkg::WIN_BITS-1:0]       cfg_data
);
    import rmhp_pkg::*;

    localparam int K_W      = (COUNT_BITS > WIN_BITS) ? COUNT_BITS : WIN_BITS;
    localparam int NUM_W    = SAMPLE_BITS + FRAC_BITS + 1 + K_W + 1;
    localparam int OUT_TD_W = ((SAMPLE_BITS + 8) / 8) * 8;

    logic [WIN_BITS-1:0]     window_reg;
    logic                    hp_reg;
    logic                    win_change;
    rmhp_status_t            status;
    rmhp_cmd_t               ctrl_cmd;
    rmhp_cmd_t               dp_cmd;
    logic signed [SAMPLE_BITS:0] filtered;
    logic                    error;

    // A new window length restarts the average from zero
    assign win_change = cfg_wr_en && (cfg_index == REG_WINDOW) && (cfg_data != window_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            hp_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_WINDOW)
            begin
                window_reg <= cfg_data;
            end
            else if (cfg_index == REG_HP_MODE)
            begin
                hp_reg <= cfg_data[0];
            end
        end
    end

    assign status.action   = s_tuser;
    assign status.win_zero = (window_reg == '0);

    always_comb
    begin
        dp_cmd       = ctrl_cmd;
        dp_cmd.clear = ctrl_cmd.clear || win_change;
    end

    rmhp_ctrl #(
        .K_W   (K_W),
        .NUM_W (NUM_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (ctrl_cmd)
    );

    rmhp_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .K_W         (K_W),
        .NUM_W       (NUM_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .sample        (s_tdata[SAMPLE_BITS-1:0]),
        .window_length (window_reg),
        .highpass_mode (hp_reg),
        .filtered      (filtered),
        .error         (error)
    );

    // Result padded with zeros to whole bytes
    assign m_tdata = OUT_TD_W'($unsigned(filtered));
    assign m_tuser = error;

endmodule

`default_nettype wire
